// ===== src/bgcd_pkg.sv =====
// Shared types and constants for the binary GCD unit.
// Used by bgcd_ctrl, bgcd_datapath and binary_gcd_unit; depends on nothing.
package bgcd_pkg;

  // Width of the operand and result ports
  localparam int unsigned FIELD_W = 64;
  // Default operand width that takes part in the computation
  localparam int unsigned DEFAULT_WIDTH = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_REDUCE,
    ST_FINISH
  } bgcd_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // take new operands, clear shift count
    logic halve_both;  // drop a common factor of two, count it
    logic halve_x;     // drop a factor of two from x
    logic halve_y;     // drop a factor of two from y
    logic subtract;    // replace the larger operand by half the difference
    logic capture;     // load the result register
  } bgcd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_odd;
    logic y_odd;
  } bgcd_status_t;

endpackage

// ===== src/bgcd_datapath.sv =====
// Operand registers, shift count, subtract/halve step and result register.
// Depends on bgcd_pkg; driven by bgcd_ctrl through bgcd_cmd_t.
module bgcd_datapath import bgcd_pkg::*; #(
  parameter int unsigned WIDTH = DEFAULT_WIDTH
) (
  input  logic               clk_i,
  input  logic [FIELD_W-1:0] operand_a_i,
  input  logic [FIELD_W-1:0] operand_b_i,
  input  bgcd_cmd_t          cmd_i,
  output bgcd_status_t       status_o,
  output logic [FIELD_W-1:0] gcd_value_o
);

  localparam int unsigned KW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic [KW-1:0]    k_q, k_d;
  logic [WIDTH-1:0] gcd_q, gcd_d;

  logic [WIDTH:0]   diff_xy;
  logic [WIDTH-1:0] diff_yx;
  logic             x_ge_y;

  assign diff_xy = {1'b0, x_q} - {1'b0, y_q};
  assign diff_yx = y_q - x_q;
  assign x_ge_y  = ~diff_xy[WIDTH];

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    k_d   = k_q;
    gcd_d = gcd_q;
    if (cmd_i.load) begin
      x_d = operand_a_i[WIDTH-1:0];
      y_d = operand_b_i[WIDTH-1:0];
      k_d = '0;
    end else if (cmd_i.halve_both) begin
      x_d = x_q >> 1;
      y_d = y_q >> 1;
      k_d = k_q + KW'(1);
    end else if (cmd_i.subtract) begin
      if (x_ge_y) begin
        x_d = diff_xy[WIDTH:1];
      end else begin
        y_d = diff_yx >> 1;
      end
    end else begin
      if (cmd_i.halve_x) begin
        x_d = x_q >> 1;
      end
      if (cmd_i.halve_y) begin
        y_d = y_q >> 1;
      end
    end
    // x is zero at the end, or one operand was zero from the start
    if (cmd_i.capture) begin
      gcd_d = (x_q | y_q) << k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    k_q   <= k_d;
    gcd_q <= gcd_d;
  end

  assign status_o.x_zero = (x_q == '0);
  assign status_o.y_zero = (y_q == '0);
  assign status_o.x_odd  = x_q[0];
  assign status_o.y_odd  = y_q[0];

  assign gcd_value_o = FIELD_W'(gcd_q);

endmodule

// ===== src/bgcd_ctrl.sv =====
// Controller state machine: input handshake, step sequencing, output word valid.
// Depends on bgcd_pkg; commands bgcd_datapath.
module bgcd_ctrl import bgcd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  bgcd_status_t status_i,
  output bgcd_cmd_t    cmd_o
);

  bgcd_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  // Output register can take a word when empty or being drained
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (status_i.x_zero || status_i.y_zero) begin
          state_d = ST_FINISH;
        end else if (status_i.x_odd || status_i.y_odd) begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status_i.x_zero) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      ST_ALIGN: begin
        cmd_o.halve_both = ~status_i.x_zero & ~status_i.y_zero &
                           ~status_i.x_odd & ~status_i.y_odd;
      end
      ST_REDUCE: begin
        if (!status_i.x_zero) begin
          cmd_o.halve_x  = ~status_i.x_odd;
          cmd_o.halve_y  = ~status_i.y_odd;
          cmd_o.subtract = status_i.x_odd & status_i.y_odd;
        end
      end
      ST_FINISH: begin
        cmd_o.capture = out_free;
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/binary_gcd_unit.sv =====
// Binary GCD unit: computes gcd(operand_a, operand_b) by the shift-and-subtract method.
// One operand pair is in flight at a time: the block stalls its input from the cycle
// after a word is accepted until the result is moved into the output register. The time an
// item takes depends on the data and is shortest when one operand is zero; it is set by the
// single subtract-or-halve step the datapath makes per cycle. The finished result waits in
// the output register, so the next pair can be accepted while the previous result is
// still stalled. Only the low WIDTH bits of each operand take part; gcd(x,0) = x and
// gcd(0,0) = 0. Depends on bgcd_pkg, bgcd_ctrl and bgcd_datapath.
module binary_gcd_unit import bgcd_pkg::*; #(
  parameter int unsigned WIDTH = DEFAULT_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FIELD_W-1:0] operand_a_i,
  input  logic [FIELD_W-1:0] operand_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FIELD_W-1:0] gcd_value_o
);

  bgcd_cmd_t    cmd;
  bgcd_status_t status;

  bgcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bgcd_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .gcd_value_o (gcd_value_o)
  );

`ifndef SYNTHESIS
  // An accepted word keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // A new result only comes out of a busy block
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while block was idle");

  // y stays nonzero throughout the reduction
  a_y_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.subtract || cmd.halve_y |-> !status.y_zero)
    else $error("y operand reached zero during reduction");
`endif

endmodule
